// ----- design/arps_pkg.sv -----
package arps_pkg;

   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned COUNT_W  = 52;
   localparam int unsigned SLOT_N   = 5;
   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned SHIFT_4K = 12;
   localparam int unsigned SHIFT_2M = 21;
   localparam int unsigned SHIFT_1G = 30;

   localparam logic [1:0] PAGE_4K = 2'd0;
   localparam logic [1:0] PAGE_2M = 2'd1;
   localparam logic [1:0] PAGE_1G = 2'd2;

   localparam logic [1:0] CONG_1G = 2'd0;
   localparam logic [1:0] CONG_2M = 2'd1;
   localparam logic [1:0] CONG_4K = 2'd2;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef enum logic [1:0] {
      MODE_1G  = 2'd0,
      MODE_2M  = 2'd1,
      MODE_4K  = 2'd2,
      MODE_ERR = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [1:0]          cong;
      logic [SLOT_N-1:0]   mask;
      logic [ADDR_W-1:0]   gb;
      logic [ADDR_W-1:0]   ge;
      logic [ADDR_W-1:0]   mb;
      logic [ADDR_W-1:0]   me;
   } plan_type;

endpackage

// ----- design/arps_req_if.sv -----
interface arps_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] virt_start;
   logic [63:0] virt_end;
   logic [63:0] phys_addr;

   modport source (output valid, output virt_start, output virt_end, output phys_addr,
                   input ready);
   modport sink (input valid, input virt_start, input virt_end, input phys_addr,
                 output ready);
endinterface

// ----- design/arps_rsp_if.sv -----
interface arps_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [2:0]  slot;
   logic [1:0]  congruence;
   logic [63:0] run_vbase;
   logic [63:0] run_pbase;
   logic [1:0]  page_size_code;
   logic [51:0] page_count;
   logic        last;

   modport source (output valid, output status, output slot, output congruence,
                   output run_vbase, output run_pbase, output page_size_code,
                   output page_count, output last, input ready);
   modport sink (input valid, input status, input slot, input congruence,
                 input run_vbase, input run_pbase, input page_size_code,
                 input page_count, input last, output ready);
endinterface

// ----- design/arps_planner.sv -----
module arps_planner (
   input  logic [arps_pkg::ADDR_W-1:0] vs,
   input  logic [arps_pkg::ADDR_W-1:0] ve,
   input  logic [arps_pkg::ADDR_W-1:0] ps,
   output arps_pkg::plan_type           plan
);

   localparam int unsigned GB_HI_W = arps_pkg::ADDR_W - arps_pkg::SHIFT_1G;
   localparam int unsigned MB_HI_W = arps_pkg::ADDR_W - arps_pkg::SHIFT_2M;

   logic [GB_HI_W:0]              gb_sum;
   logic [MB_HI_W:0]              mb_sum;
   logic                          gb_ok;
   logic                          mb_ok;
   logic [arps_pkg::ADDR_W-1:0]   gb;
   logic [arps_pkg::ADDR_W-1:0]   ge;
   logic [arps_pkg::ADDR_W-1:0]   mb;
   logic [arps_pkg::ADDR_W-1:0]   me;
   logic [1:0]                    cong;
   logic                          err;
   logic                          use_1g;
   logic                          use_2m;
   logic [arps_pkg::ADDR_W-1:0]   any_addr;

   always_comb begin
      any_addr = vs | ve | ps;
      err = (any_addr[arps_pkg::SHIFT_4K-1:0] != '0) || (vs >= ve);

      gb_sum = {1'b0, vs[arps_pkg::ADDR_W-1:arps_pkg::SHIFT_1G]}
               + (GB_HI_W+1)'(|vs[arps_pkg::SHIFT_1G-1:0]);
      mb_sum = {1'b0, vs[arps_pkg::ADDR_W-1:arps_pkg::SHIFT_2M]}
               + (MB_HI_W+1)'(|vs[arps_pkg::SHIFT_2M-1:0]);
      gb_ok = !gb_sum[GB_HI_W];
      mb_ok = !mb_sum[MB_HI_W];
      gb = {gb_sum[GB_HI_W-1:0], arps_pkg::SHIFT_1G'(0)};
      mb = {mb_sum[MB_HI_W-1:0], arps_pkg::SHIFT_2M'(0)};
      ge = {ve[arps_pkg::ADDR_W-1:arps_pkg::SHIFT_1G], arps_pkg::SHIFT_1G'(0)};
      me = {ve[arps_pkg::ADDR_W-1:arps_pkg::SHIFT_2M], arps_pkg::SHIFT_2M'(0)};

      if (vs[arps_pkg::SHIFT_1G-1:0] == ps[arps_pkg::SHIFT_1G-1:0]) begin
         cong = arps_pkg::CONG_1G;
      end else if (vs[arps_pkg::SHIFT_2M-1:0] == ps[arps_pkg::SHIFT_2M-1:0]) begin
         cong = arps_pkg::CONG_2M;
      end else begin
         cong = arps_pkg::CONG_4K;
      end

      use_1g = (cong == arps_pkg::CONG_1G) && gb_ok && (ge > gb);
      use_2m = !use_1g && (cong != arps_pkg::CONG_4K) && mb_ok && (mb < me);

      plan.gb   = gb;
      plan.ge   = ge;
      plan.mb   = mb;
      plan.me   = me;
      plan.cong = cong;
      if (err) begin
         plan.mode = arps_pkg::MODE_ERR;
         plan.mask = arps_pkg::SLOT_N'(1);
         plan.cong = arps_pkg::CONG_1G;
      end else if (use_1g) begin
         plan.mode = arps_pkg::MODE_1G;
         plan.mask = {me < ve, vs < mb, ge < me, mb < gb, 1'b1};
      end else if (use_2m) begin
         plan.mode = arps_pkg::MODE_2M;
         plan.mask = {2'b00, me < ve, vs < mb, 1'b1};
      end else begin
         plan.mode = arps_pkg::MODE_4K;
         plan.mask = arps_pkg::SLOT_N'(1);
      end
   end

endmodule

// ----- design/address_range_page_splitter.sv -----
// Address range page splitter.
// req_chan (sink): one transfer carries virt_start, virt_end and phys_addr of a
// range. rsp_chan (source): each request yields 1 to 5 page-run transfers in
// slot order; the final one has last set. A misaligned or empty range yields a
// single transfer with status and last set and all other fields zero.
// Pipeline: input register, plan register (page boundaries and slot mask),
// output register; each run of a request passes from the plan register to the
// output register. The plan register emits one run per cycle while rsp_chan
// does not stall and holds a request until its last run is emitted; a new
// request is taken every cycle while requests give one run each and rsp_chan
// does not stall. When rsp_chan stalls, the output register holds its transfer,
// the plan register and then the input register fill, and req_chan.ready drops.
// Reset (synchronous) empties all three stages; no result is pending after it.
module address_range_page_splitter (
   input  logic       clock,
   input  logic       reset,
   arps_req_if.sink   req_chan,
   arps_rsp_if.source rsp_chan
);

   logic                          a_valid_ff, a_valid_in;
   logic [arps_pkg::ADDR_W-1:0]   a_vs_ff, a_ve_ff, a_ps_ff;

   logic                          b_valid_ff, b_valid_in;
   logic [arps_pkg::SLOT_N-1:0]   b_rem_ff, b_rem_in;
   arps_pkg::plan_type            b_plan_ff;
   logic [arps_pkg::ADDR_W-1:0]   b_vs_ff, b_ve_ff, b_ps_ff;

   logic                          o_valid_ff, o_valid_in;
   logic                          o_status_ff, o_status_in;
   logic [arps_pkg::SLOT_W-1:0]   o_slot_ff, o_slot_in;
   logic [1:0]                    o_cong_ff, o_cong_in;
   logic [arps_pkg::ADDR_W-1:0]   o_vbase_ff, o_vbase_in;
   logic [arps_pkg::ADDR_W-1:0]   o_pbase_ff, o_pbase_in;
   logic [1:0]                    o_code_ff, o_code_in;
   logic [arps_pkg::COUNT_W-1:0]  o_count_ff, o_count_in;
   logic                          o_last_ff, o_last_in;

   arps_pkg::plan_type            plan;
   logic                          req_take;
   logic                          out_free;
   logic                          emit;
   logic                          b_load;
   logic [arps_pkg::SLOT_N-1:0]   sel;
   logic [arps_pkg::SLOT_N-1:0]   rem_next;
   logic [arps_pkg::SLOT_W-1:0]   sel_idx;
   logic                          found;
   logic [arps_pkg::ADDR_W-1:0]   run_base;
   logic [arps_pkg::ADDR_W-1:0]   run_end;
   logic [arps_pkg::ADDR_W-1:0]   run_len;
   logic [1:0]                    run_code;

   arps_planner u_planner (
      .vs   (a_vs_ff),
      .ve   (a_ve_ff),
      .ps   (a_ps_ff),
      .plan (plan)
   );

   always_comb begin
      sel     = '0;
      sel_idx = '0;
      found   = 1'b0;
      for (int i = 0; i < arps_pkg::SLOT_N; i++) begin
         if (b_rem_ff[i] && !found) begin
            sel[i]  = 1'b1;
            sel_idx = arps_pkg::SLOT_W'(i);
            found   = 1'b1;
         end
      end
      rem_next = b_rem_ff & ~sel;
   end

   always_comb begin
      run_base = b_vs_ff;
      run_end  = b_ve_ff;
      run_code = arps_pkg::PAGE_4K;
      case (b_plan_ff.mode)
         arps_pkg::MODE_1G: begin
            case (sel_idx)
               3'd0: begin
                  run_base = b_plan_ff.gb;
                  run_end  = b_plan_ff.ge;
                  run_code = arps_pkg::PAGE_1G;
               end
               3'd1: begin
                  run_base = b_plan_ff.mb;
                  run_end  = b_plan_ff.gb;
                  run_code = arps_pkg::PAGE_2M;
               end
               3'd2: begin
                  run_base = b_plan_ff.ge;
                  run_end  = b_plan_ff.me;
                  run_code = arps_pkg::PAGE_2M;
               end
               3'd3: begin
                  run_base = b_vs_ff;
                  run_end  = b_plan_ff.mb;
               end
               default: begin
                  run_base = b_plan_ff.me;
                  run_end  = b_ve_ff;
               end
            endcase
         end
         arps_pkg::MODE_2M: begin
            case (sel_idx)
               3'd0: begin
                  run_base = b_plan_ff.mb;
                  run_end  = b_plan_ff.me;
                  run_code = arps_pkg::PAGE_2M;
               end
               3'd1: begin
                  run_base = b_vs_ff;
                  run_end  = b_plan_ff.mb;
               end
               default: begin
                  run_base = b_plan_ff.me;
                  run_end  = b_ve_ff;
               end
            endcase
         end
         default: begin
            run_base = b_vs_ff;
            run_end  = b_ve_ff;
         end
      endcase
      run_len = run_end - run_base;
   end

   always_comb begin
      out_free = !o_valid_ff || rsp_chan.ready;
      emit     = b_valid_ff && out_free;
      b_load   = !b_valid_ff || (emit && (rem_next == '0));
      req_take = req_chan.valid && req_chan.ready;

      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (b_load) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end

      b_valid_in = b_load ? a_valid_ff : b_valid_ff;
      if (b_load) begin
         b_rem_in = plan.mask;
      end else if (emit) begin
         b_rem_in = rem_next;
      end else begin
         b_rem_in = b_rem_ff;
      end

      if (emit) begin
         o_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end

      o_last_in = (rem_next == '0);
      if (b_plan_ff.mode == arps_pkg::MODE_ERR) begin
         o_status_in = arps_pkg::STATUS_INVALID;
         o_slot_in   = '0;
         o_cong_in   = arps_pkg::CONG_1G;
         o_vbase_in  = '0;
         o_pbase_in  = '0;
         o_code_in   = arps_pkg::PAGE_4K;
         o_count_in  = '0;
      end else begin
         o_status_in = arps_pkg::STATUS_OK;
         o_slot_in   = sel_idx;
         o_cong_in   = b_plan_ff.cong;
         o_vbase_in  = run_base;
         o_pbase_in  = b_ps_ff + (run_base - b_vs_ff);
         o_code_in   = run_code;
         case (run_code)
            arps_pkg::PAGE_1G: o_count_in = arps_pkg::COUNT_W'(run_len >> arps_pkg::SHIFT_1G);
            arps_pkg::PAGE_2M: o_count_in = arps_pkg::COUNT_W'(run_len >> arps_pkg::SHIFT_2M);
            default:           o_count_in = run_len[arps_pkg::ADDR_W-1:arps_pkg::SHIFT_4K];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_rem_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_rem_ff   <= b_rem_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_vs_ff <= req_chan.virt_start;
         a_ve_ff <= req_chan.virt_end;
         a_ps_ff <= req_chan.phys_addr;
      end
      if (b_load) begin
         b_plan_ff <= plan;
         b_vs_ff   <= a_vs_ff;
         b_ve_ff   <= a_ve_ff;
         b_ps_ff   <= a_ps_ff;
      end
      if (emit) begin
         o_status_ff <= o_status_in;
         o_slot_ff   <= o_slot_in;
         o_cong_ff   <= o_cong_in;
         o_vbase_ff  <= o_vbase_in;
         o_pbase_ff  <= o_pbase_in;
         o_code_ff   <= o_code_in;
         o_count_ff  <= o_count_in;
         o_last_ff   <= o_last_in;
      end
   end

   assign req_chan.ready          = !a_valid_ff || b_load;
   assign rsp_chan.valid          = o_valid_ff;
   assign rsp_chan.status         = o_status_ff;
   assign rsp_chan.slot           = o_slot_ff;
   assign rsp_chan.congruence     = o_cong_ff;
   assign rsp_chan.run_vbase      = o_vbase_ff;
   assign rsp_chan.run_pbase      = o_pbase_ff;
   assign rsp_chan.page_size_code = o_code_ff;
   assign rsp_chan.page_count     = o_count_ff;
   assign rsp_chan.last           = o_last_ff;

endmodule

// ----- design/arps_checker.sv -----
module arps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [2:0]  rsp_slot,
   input logic [63:0] rsp_run_vbase,
   input logic [51:0] rsp_page_count,
   input logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == arps_pkg::STATUS_INVALID) |->
      (rsp_last && rsp_slot == '0 && rsp_page_count == '0 && rsp_run_vbase == '0))
      else $error("invalid-range result not a single zeroed transfer");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == arps_pkg::STATUS_OK) |-> (rsp_page_count != '0))
      else $error("empty page run");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
      (!rsp_valid || (rsp_status == arps_pkg::STATUS_OK && rsp_slot > $past(rsp_slot))))
      else $error("runs of one request out of slot order");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_slot) && $stable(rsp_run_vbase) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind address_range_page_splitter arps_checker u_arps_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_slot       (rsp_chan.slot),
   .rsp_run_vbase  (rsp_chan.run_vbase),
   .rsp_page_count (rsp_chan.page_count),
   .rsp_last       (rsp_chan.last)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam logic [arps_pkg::ADDR_W-1:0] SZ_4K = 64'h0000_0000_0000_1000;
   localparam logic [arps_pkg::ADDR_W-1:0] SZ_2M = 64'h0000_0000_0020_0000;
   localparam logic [arps_pkg::ADDR_W-1:0] SZ_1G = 64'h0000_0000_4000_0000;
   localparam logic [arps_pkg::ADDR_W-1:0] TOP_PAGE = 64'hFFFF_FFFF_FFFF_F000;
   localparam int RANDOM_ITEMS = 220;
   localparam int SETTLE_CYCLES = 20;
   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic                         status;
      logic [arps_pkg::SLOT_W-1:0]  slot;
      logic [1:0]                   congruence;
      logic [arps_pkg::ADDR_W-1:0]  vbase;
      logic [arps_pkg::ADDR_W-1:0]  pbase;
      logic [1:0]                   size_code;
      logic [arps_pkg::COUNT_W-1:0] count;
      logic                         last;
   } page_run_type;

   logic clock = 1'b0;
   logic reset;

   arps_req_if req_chan ();
   arps_rsp_if rsp_chan ();

   address_range_page_splitter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   page_run_type pending_runs[$];
   int unsigned cycle_count = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int requests_rejected = 0;
   int runs_checked = 0;
   int runs_by_size[3] = '{0, 0, 0};
   int idle_mode = 0;
   int rsp_stall = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d runs outstanding", cycle_count,
                  pending_runs.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // idle profile is redrawn whenever cycle_count[6:0] is zero: none, light or heavy
   always @(negedge clock) begin
      if (cycle_count[6:0] == 7'd0) begin
         idle_mode <= $urandom_range(0, 2);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_mode == 0) return 0;
      if (r < ((idle_mode == 1) ? 70 : 35)) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   function automatic page_run_type make_run(logic status,
                                             logic [arps_pkg::SLOT_W-1:0] slot,
                                             logic [1:0] cong,
                                             logic [arps_pkg::ADDR_W-1:0] vbase,
                                             logic [arps_pkg::ADDR_W-1:0] pbase,
                                             logic [1:0] size_code,
                                             logic [arps_pkg::ADDR_W-1:0] count);
      page_run_type run;
      run.status     = status;
      run.slot       = slot;
      run.congruence = cong;
      run.vbase      = vbase;
      run.pbase      = pbase;
      run.size_code  = size_code;
      run.count      = count[arps_pkg::COUNT_W-1:0];
      run.last       = 1'b0;
      return run;
   endfunction

   function automatic logic fits_round_up(logic [arps_pkg::ADDR_W-1:0] x,
                                          logic [arps_pkg::ADDR_W-1:0] sz);
      return x <= ~(sz - 1);
   endfunction

   function automatic logic [arps_pkg::ADDR_W-1:0] round_up(
         logic [arps_pkg::ADDR_W-1:0] x, logic [arps_pkg::ADDR_W-1:0] sz);
      return (x + sz - 1) & ~(sz - 1);
   endfunction

   function automatic void split_range(logic [arps_pkg::ADDR_W-1:0] vs,
                                       logic [arps_pkg::ADDR_W-1:0] ve,
                                       logic [arps_pkg::ADDR_W-1:0] ps);
      page_run_type runs[$];
      logic [1:0] cong;
      logic [arps_pkg::ADDR_W-1:0] gb, ge, mb, me;
      logic done;
      done = 1'b0;
      if (((vs | ve | ps) & (SZ_4K - 1)) != 0 || vs >= ve) begin
         runs.push_back(make_run(arps_pkg::STATUS_INVALID, 3'd0, arps_pkg::CONG_1G, '0, '0,
                                 arps_pkg::PAGE_4K, '0));
      end else begin
         if ((vs & (SZ_1G - 1)) == (ps & (SZ_1G - 1))) cong = arps_pkg::CONG_1G;
         else if ((vs & (SZ_2M - 1)) == (ps & (SZ_2M - 1))) cong = arps_pkg::CONG_2M;
         else cong = arps_pkg::CONG_4K;

         if (cong == arps_pkg::CONG_1G && fits_round_up(vs, SZ_1G)) begin
            gb = round_up(vs, SZ_1G);
            ge = ve & ~(SZ_1G - 1);
            if (ge > gb) begin
               mb = round_up(vs, SZ_2M);
               me = ve & ~(SZ_2M - 1);
               runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd0, cong, gb, ps + (gb - vs),
                                       arps_pkg::PAGE_1G, (ge - gb) >> arps_pkg::SHIFT_1G));
               if (mb < gb)
                  runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd1, cong, mb,
                                          ps + (mb - vs), arps_pkg::PAGE_2M,
                                          (gb - mb) >> arps_pkg::SHIFT_2M));
               if (ge < me)
                  runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd2, cong, ge,
                                          ps + (ge - vs), arps_pkg::PAGE_2M,
                                          (me - ge) >> arps_pkg::SHIFT_2M));
               if (vs < mb)
                  runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd3, cong, vs, ps,
                                          arps_pkg::PAGE_4K,
                                          (mb - vs) >> arps_pkg::SHIFT_4K));
               if (me < ve)
                  runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd4, cong, me,
                                          ps + (me - vs), arps_pkg::PAGE_4K,
                                          (ve - me) >> arps_pkg::SHIFT_4K));
               done = 1'b1;
            end
         end

         if (!done && cong != arps_pkg::CONG_4K && fits_round_up(vs, SZ_2M)) begin
            mb = round_up(vs, SZ_2M);
            me = ve & ~(SZ_2M - 1);
            if (mb < me) begin
               runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd0, cong, mb, ps + (mb - vs),
                                       arps_pkg::PAGE_2M, (me - mb) >> arps_pkg::SHIFT_2M));
               if (vs < mb)
                  runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd1, cong, vs, ps,
                                          arps_pkg::PAGE_4K,
                                          (mb - vs) >> arps_pkg::SHIFT_4K));
               if (me < ve)
                  runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd2, cong, me,
                                          ps + (me - vs), arps_pkg::PAGE_4K,
                                          (ve - me) >> arps_pkg::SHIFT_4K));
               done = 1'b1;
            end
         end

         if (!done)
            runs.push_back(make_run(arps_pkg::STATUS_OK, 3'd0, cong, vs, ps,
                                    arps_pkg::PAGE_4K, (ve - vs) >> arps_pkg::SHIFT_4K));
      end
      runs[runs.size() - 1].last = 1'b1;
      foreach (runs[i]) pending_runs.push_back(runs[i]);
   endfunction

   function automatic string show_run(page_run_type r);
      return $sformatf("st=%0b slot=%0d cong=%0d v=%h p=%h size=%0d n=%h last=%0b",
                       r.status, r.slot, r.congruence, r.vbase, r.pbase, r.size_code,
                       r.count, r.last);
   endfunction

   always @(posedge clock) begin : check_runs
      page_run_type got, want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.status     = rsp_chan.status;
         got.slot       = rsp_chan.slot;
         got.congruence = rsp_chan.congruence;
         got.vbase      = rsp_chan.run_vbase;
         got.pbase      = rsp_chan.run_pbase;
         got.size_code  = rsp_chan.page_size_code;
         got.count      = rsp_chan.page_count;
         got.last       = rsp_chan.last;
         if (pending_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected transfer: %s", $realtime, show_run(got));
         end else begin
            want = pending_runs.pop_front();
            runs_checked++;
            if (want.status == arps_pkg::STATUS_OK) runs_by_size[want.size_code]++;
            if (got.status !== want.status || got.slot !== want.slot ||
                got.congruence !== want.congruence || got.vbase !== want.vbase ||
                got.pbase !== want.pbase || got.size_code !== want.size_code ||
                got.count !== want.count || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: run mismatch", $realtime);
                  $display("   expected %s", show_run(want));
                  $display("   actual   %s", show_run(got));
               end
            end
         end
      end
   end

   // valid stays high after a transfer so that back-to-back requests are possible
   task automatic send_range(logic [arps_pkg::ADDR_W-1:0] vs,
                             logic [arps_pkg::ADDR_W-1:0] ve,
                             logic [arps_pkg::ADDR_W-1:0] ps);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.virt_start <= vs;
      req_chan.virt_end   <= ve;
      req_chan.phys_addr  <= ps;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      split_range(vs, ve, ps);
      requests_sent++;
      if (((vs | ve | ps) & (SZ_4K - 1)) != 0 || vs >= ve) requests_rejected++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_runs.size() != 0) @(negedge clock);
   endtask

   function automatic logic [arps_pkg::ADDR_W-1:0] rand_page();
      logic [arps_pkg::ADDR_W-1:0] v;
      v = {$urandom, $urandom};
      v[11:0] = '0;
      return v;
   endfunction

   task automatic test_invalid_ranges();
      send_range(64'h1001, 64'h5000, 64'h1000);
      send_range(64'h1000, 64'h5800, 64'h1000);
      send_range(64'h1000, 64'h5000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_range(64'h7000, 64'h7000, 64'h7000);
      send_range(64'h8000, 64'h3000, 64'h8000);
   endtask

   task automatic test_small_page_split();
      send_range(64'h1000, 64'h5000, 64'h3000);
      send_range(64'h0, TOP_PAGE, 64'h1000);
      send_range(64'h1000, 64'h3000, 64'h1000);
   endtask

   task automatic test_mid_page_split();
      send_range(64'h1F_F000, 64'h60_3000, 64'h3F_F000);
      send_range(64'h20_1000, 64'h3F_F000, 64'h40_1000);
      send_range(64'h1F_F000, 64'h3FFF_F000, 64'h1F_F000);
   endtask

   task automatic test_large_page_split();
      send_range(64'h3FDF_F000, 64'h8020_1000, 64'h1_3FDF_F000);
      send_range(64'h4000_0000, 64'h8000_0000, 64'hC000_0000);
      send_range(64'h0, TOP_PAGE, 64'h0);
   endtask

   task automatic test_address_space_edges();
      send_range(64'hFFFF_FFFF_C000_1000, TOP_PAGE, 64'hFFFF_FFFF_C000_1000);
      send_range(64'hFFFF_FFFF_FFE0_1000, TOP_PAGE, 64'h1234_5678_BFE0_1000);
      send_range(64'h0, 64'h8000_0000, 64'hFFFF_FFFF_C000_0000);
      send_range(64'hFFFF_FFFF_0000_0000, TOP_PAGE, 64'h4000_0000);
   endtask

   task automatic test_random_ranges();
      logic [arps_pkg::ADDR_W-1:0] vs, ve, ps, len, tmp;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         vs = rand_page();
         case ($urandom_range(0, 3))
            0: vs[29:12] = 18'($urandom_range(0, 3));
            1: vs[29:12] = 18'h3FFFF - 18'($urandom_range(0, 3));
            2: vs[20:12] = 9'h1FF - 9'($urandom_range(0, 3));
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0: len = 64'($urandom_range(1, 600)) << arps_pkg::SHIFT_4K;
            1: len = 64'($urandom & 32'h3_FFFF) << arps_pkg::SHIFT_4K;
            2: len = {28'h0, 4'($urandom_range(0, 15)), $urandom} << arps_pkg::SHIFT_4K;
            default: len = rand_page();
         endcase
         ve = vs + len;
         if (ve < vs) begin
            ve = TOP_PAGE;
            if (vs == TOP_PAGE) vs = TOP_PAGE - SZ_2M;
         end
         ps = rand_page();
         case ($urandom_range(0, 2))
            0: ps[29:0] = vs[29:0];
            1: ps[20:0] = vs[20:0];
            default: ;
         endcase
         if ($urandom_range(0, 99) >= 85) begin
            case ($urandom_range(0, 3))
               0: begin
                  vs = {$urandom, $urandom};
                  ve = {$urandom, $urandom};
                  ps = {$urandom, $urandom};
               end
               1: ve = vs;
               2: begin
                  tmp = vs;
                  vs = ve;
                  ve = tmp;
               end
               default: begin
                  vs[11:0] = 12'($urandom);
                  ve[11:0] = 12'($urandom);
                  ps[11:0] = 12'($urandom);
               end
            endcase
         end
         send_range(vs, ve, ps);
         if (i == RANDOM_ITEMS / 2) wait_for_drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.virt_start = '0;
      req_chan.virt_end = '0;
      req_chan.phys_addr = '0;
      rsp_chan.ready = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_invalid_ranges();
      test_small_page_split();
      test_mid_page_split();
      test_large_page_split();
      test_address_space_edges();
      test_random_ranges();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("requests: %0d sent, %0d rejected as misaligned or empty", requests_sent,
               requests_rejected);
      $display("runs checked: %0d (1GB %0d, 2MB %0d, 4KB %0d), mismatches %0d, missing %0d",
               runs_checked, runs_by_size[arps_pkg::PAGE_1G],
               runs_by_size[arps_pkg::PAGE_2M], runs_by_size[arps_pkg::PAGE_4K],
               mismatches, pending_runs.size());
      if (mismatches == 0 && pending_runs.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
